### src/isst_pkg.sv
`timescale 1ns / 1ps
package isst_pkg;

	localparam int MAX_SETS    = 256;
	localparam int MAX_SET_LEN = 32;
	localparam int ELEM_W      = 16;
	localparam int IDX_W       = 8;
	localparam int POS_W       = 5;
	localparam int LEN_W       = 6;
	localparam int CNT_W       = 9;
	localparam int ADDR_W      = IDX_W + POS_W;
	localparam int STORE_DEPTH = MAX_SETS * MAX_SET_LEN;

	localparam logic [1:0] OP_MEMBER = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_UNION  = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NOT_STORED = 2'd1;
	localparam logic [1:0] ST_FULL       = 2'd2;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [IDX_W-1:0]  set_index;
		logic [ELEM_W-1:0] element;
		logic [IDX_W-1:0]  other_set;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] result_set;
		logic             is_member;
		logic [1:0]       status;
	} out_item_t;

	typedef enum logic [4:0] {
		CMD_NONE, CMD_CAPTURE, CMD_CHECK, CMD_M_LEN, CMD_M_RD, CMD_M_CMP,
		CMD_U_LEN, CMD_U_NEXT, CMD_U_ELEM, CMD_A_START, CMD_B_LEN, CMD_B_RD,
		CMD_B_MRG, CMD_S_LEN, CMD_S_LCHK, CMD_S_RD, CMD_S_CMP, CMD_N_CHK,
		CMD_W_WR, CMD_A_RET, CMD_EMIT
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       err;
		logic       e_zero;
		logic       i_end;
		logic       k_end;
		logic       len_match;
		logic       j_end;
		logic       data_eq;
		logic       too_long;
		logic       full;
		logic       uj_end;
	} dp_status_t;

endpackage

### src/isst_datapath.sv
`timescale 1ns / 1ps
module isst_datapath import isst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   item,
	input  cmd_t       cmd,
	output dp_status_t status,
	output logic       done,
	output out_item_t  result
);

	logic [ELEM_W-1:0] store_mem [STORE_DEPTH];
	logic [LEN_W-1:0]  len_mem [MAX_SETS];

	logic [1:0]        op_q;
	logic [IDX_W-1:0]  si_q, os_q, cur_q, res_q;
	logic [ELEM_W-1:0] e_q;
	logic              mem_q, ins_q;
	logic [1:0]        st_q;
	logic [LEN_W-1:0]  blen_q, i_q, clen_q, j_q, ulen_q, uj_q;
	logic [CNT_W-1:0]  k_q, count_q;
	logic [ELEM_W-1:0] cand_q [MAX_SET_LEN];

	logic [ADDR_W-1:0] store_raddr;
	logic [ELEM_W-1:0] store_rd_q;
	logic [IDX_W-1:0]  len_raddr, len_addr_q;
	logic [LEN_W-1:0]  len_rd_q, len_out;
	logic              si_ok, os_ok, keep_x;
	logic [ELEM_W-1:0] cand_j;
	logic              done_q;
	out_item_t         result_q;

	always_comb begin
		unique case (cmd)
			CMD_M_RD:   store_raddr = {si_q, i_q[POS_W-1:0]};
			CMD_U_NEXT: store_raddr = {os_q, uj_q[POS_W-1:0]};
			CMD_B_RD:   store_raddr = {cur_q, i_q[POS_W-1:0]};
			CMD_S_RD:   store_raddr = {k_q[IDX_W-1:0], j_q[POS_W-1:0]};
			default:    store_raddr = '0;
		endcase
		unique case (cmd)
			CMD_CHECK:   len_raddr = (op_q == OP_UNION) ? os_q : si_q;
			CMD_A_START: len_raddr = cur_q;
			CMD_S_LEN:   len_raddr = k_q[IDX_W-1:0];
			default:     len_raddr = '0;
		endcase
	end

	// Set 0 is the empty set; its length entry is never written.
	assign len_out = (len_addr_q == '0) ? '0 : len_rd_q;
	assign cand_j  = cand_q[j_q[POS_W-1:0]];
	assign si_ok   = {1'b0, si_q} < count_q;
	assign os_ok   = {1'b0, os_q} < count_q;
	assign keep_x  = ins_q || (store_rd_q <= e_q);

	always_comb begin
		status.op        = op_q;
		status.err       = (op_q == OP_UNION) ? !(si_ok && os_ok) :
			((op_q == OP_MEMBER || op_q == OP_ADD) && !si_ok);
		status.e_zero    = (e_q == '0);
		status.i_end     = (i_q == blen_q);
		status.k_end     = (k_q == count_q);
		status.len_match = (len_out == clen_q);
		status.j_end     = (j_q == clen_q);
		status.data_eq   = (store_rd_q == cand_j);
		status.too_long  = ({1'b0, clen_q} + 7'd1) >= 7'(MAX_SET_LEN);
		status.full      = (count_q == CNT_W'(MAX_SETS));
		status.uj_end    = (uj_q == ulen_q);
	end

	always_ff @(posedge clk) begin
		store_rd_q <= store_mem[store_raddr];
		len_rd_q   <= len_mem[len_raddr];
		len_addr_q <= len_raddr;
		if (cmd == CMD_W_WR && !status.j_end)
			store_mem[{count_q[IDX_W-1:0], j_q[POS_W-1:0]}] <= cand_j;
		if (cmd == CMD_W_WR && status.j_end)
			len_mem[count_q[IDX_W-1:0]] <= clen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
			done_q  <= 1'b0;
		end else begin
			done_q <= (cmd == CMD_EMIT);
			if (cmd == CMD_W_WR && status.j_end)
				count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_CAPTURE: begin
				op_q  <= item.opcode;
				si_q  <= item.set_index;
				os_q  <= item.other_set;
				e_q   <= item.element;
				res_q <= item.set_index;
				mem_q <= 1'b0;
				st_q  <= ST_OK;
			end
			CMD_CHECK: begin
				cur_q <= si_q;
				if (status.err)
					st_q <= ST_NOT_STORED;
			end
			CMD_M_LEN: begin
				blen_q <= len_out;
				i_q    <= '0;
			end
			CMD_M_CMP: begin
				if (store_rd_q == e_q)
					mem_q <= 1'b1;
				i_q <= i_q + LEN_W'(1);
			end
			CMD_U_LEN: begin
				ulen_q <= len_out;
				uj_q   <= '0;
			end
			CMD_U_NEXT: begin
				if (status.uj_end)
					res_q <= cur_q;
			end
			CMD_U_ELEM: begin
				e_q  <= store_rd_q;
				uj_q <= uj_q + LEN_W'(1);
			end
			CMD_A_START: begin
				if (status.e_zero)
					res_q <= cur_q;
			end
			CMD_B_LEN: begin
				blen_q <= len_out;
				i_q    <= '0;
				clen_q <= '0;
				ins_q  <= 1'b0;
			end
			CMD_B_RD: begin
				if (status.i_end) begin
					k_q <= '0;
					if (!ins_q) begin
						cand_q[clen_q[POS_W-1:0]] <= e_q;
						clen_q <= clen_q + LEN_W'(1);
					end
				end
			end
			CMD_B_MRG: begin
				// Insert the new word ahead of the first larger base word.
				clen_q <= clen_q + LEN_W'(1);
				if (keep_x) begin
					cand_q[clen_q[POS_W-1:0]] <= store_rd_q;
					i_q <= i_q + LEN_W'(1);
					if (store_rd_q == e_q)
						ins_q <= 1'b1;
				end else begin
					cand_q[clen_q[POS_W-1:0]] <= e_q;
					ins_q <= 1'b1;
				end
			end
			CMD_S_LCHK: begin
				if (status.len_match)
					j_q <= '0;
				else
					k_q <= k_q + CNT_W'(1);
			end
			CMD_S_RD: begin
				if (status.j_end)
					res_q <= k_q[IDX_W-1:0];
			end
			CMD_S_CMP: begin
				if (status.data_eq)
					j_q <= j_q + LEN_W'(1);
				else
					k_q <= k_q + CNT_W'(1);
			end
			CMD_N_CHK: begin
				if (status.too_long) begin
					res_q <= cur_q;
				end else if (status.full) begin
					res_q <= si_q;
					st_q  <= ST_FULL;
				end else begin
					j_q <= '0;
				end
			end
			CMD_W_WR: begin
				if (status.j_end)
					res_q <= count_q[IDX_W-1:0];
				else
					j_q <= j_q + LEN_W'(1);
			end
			CMD_A_RET: cur_q <= res_q;
			CMD_EMIT: begin
				result_q.result_set <= res_q;
				result_q.is_member  <= mem_q;
				result_q.status     <= st_q;
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### src/isst_ctrl.sv
`timescale 1ns / 1ps
module isst_ctrl import isst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output cmd_t       cmd,
	output logic       busy
);

	typedef enum logic [19:0] {
		S_IDLE   = 20'h00001, S_CHECK  = 20'h00002, S_M_LEN  = 20'h00004,
		S_M_RD   = 20'h00008, S_M_CMP  = 20'h00010, S_U_LEN  = 20'h00020,
		S_U_NEXT = 20'h00040, S_U_ELEM = 20'h00080, S_A_START = 20'h00100,
		S_B_LEN  = 20'h00200, S_B_RD   = 20'h00400, S_B_MRG  = 20'h00800,
		S_S_LEN  = 20'h01000, S_S_LCHK = 20'h02000, S_S_RD   = 20'h04000,
		S_S_CMP  = 20'h08000, S_N_CHK  = 20'h10000, S_W_WR   = 20'h20000,
		S_A_RET  = 20'h40000, S_EMIT   = 20'h80000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd     = CMD_CAPTURE;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd = CMD_CHECK;
				if (status.err)
					state_d = S_EMIT;
				else if (status.op == OP_MEMBER)
					state_d = status.e_zero ? S_EMIT : S_M_LEN;
				else if (status.op == OP_ADD)
					state_d = S_A_START;
				else if (status.op == OP_UNION)
					state_d = S_U_LEN;
				else
					state_d = S_EMIT;
			end
			S_M_LEN: begin
				cmd     = CMD_M_LEN;
				state_d = S_M_RD;
			end
			S_M_RD: begin
				cmd     = CMD_M_RD;
				state_d = status.i_end ? S_EMIT : S_M_CMP;
			end
			S_M_CMP: begin
				cmd     = CMD_M_CMP;
				state_d = S_M_RD;
			end
			S_U_LEN: begin
				cmd     = CMD_U_LEN;
				state_d = S_U_NEXT;
			end
			S_U_NEXT: begin
				cmd     = CMD_U_NEXT;
				state_d = status.uj_end ? S_EMIT : S_U_ELEM;
			end
			S_U_ELEM: begin
				cmd     = CMD_U_ELEM;
				state_d = S_A_START;
			end
			S_A_START: begin
				cmd     = CMD_A_START;
				state_d = status.e_zero ? S_A_RET : S_B_LEN;
			end
			S_B_LEN: begin
				cmd     = CMD_B_LEN;
				state_d = S_B_RD;
			end
			S_B_RD: begin
				cmd     = CMD_B_RD;
				state_d = status.i_end ? S_S_LEN : S_B_MRG;
			end
			S_B_MRG: begin
				cmd     = CMD_B_MRG;
				state_d = S_B_RD;
			end
			S_S_LEN: begin
				cmd     = CMD_S_LEN;
				state_d = status.k_end ? S_N_CHK : S_S_LCHK;
			end
			S_S_LCHK: begin
				cmd     = CMD_S_LCHK;
				state_d = status.len_match ? S_S_RD : S_S_LEN;
			end
			S_S_RD: begin
				cmd     = CMD_S_RD;
				state_d = status.j_end ? S_A_RET : S_S_CMP;
			end
			S_S_CMP: begin
				cmd     = CMD_S_CMP;
				state_d = status.data_eq ? S_S_RD : S_S_LEN;
			end
			S_N_CHK: begin
				cmd = CMD_N_CHK;
				if (status.too_long)
					state_d = S_A_RET;
				else if (status.full)
					state_d = S_EMIT;
				else
					state_d = S_W_WR;
			end
			S_W_WR: begin
				cmd     = CMD_W_WR;
				state_d = status.j_end ? S_A_RET : S_W_WR;
			end
			S_A_RET: begin
				cmd     = CMD_A_RET;
				state_d = (status.op == OP_UNION) ? S_U_NEXT : S_EMIT;
			end
			S_EMIT: begin
				cmd     = CMD_EMIT;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

### src/interned_sorted_set_table_unit.sv
`timescale 1ns / 1ps
// Channel   Ports                 Moves a word when
// command   start, busy, item     start high while busy is low
// result    done, result          done high (one cycle, cannot be held off)
//
// One word at a time. Membership reads each element of the set in turn.
// An add merges the new element into the base set to build the candidate,
// searches the table by checking the length of each stored set and
// comparing elements while they match, and appends the candidate if no
// stored set matches and there is room; a union repeats the add once per
// element of the other set. Reset clears the controller and the set count
// at once; no clearing pass is needed.
module interned_sorted_set_table_unit import isst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output logic      done,
	output out_item_t result
);

	cmd_t       cmd;
	dp_status_t status;

	isst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	isst_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.done   (done),
		.result (result)
	);

endmodule

### src/isst_checker.sv
`timescale 1ns / 1ps
module isst_checker import isst_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input in_item_t  item,
	input logic      done,
	input out_item_t result
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result word shown while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted word did not start work");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status <= ST_FULL)) else $error("undefined status code");

	a_member_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.is_member) |-> (result.status == ST_OK))
		else $error("member flag with error status");

endmodule

bind interned_sorted_set_table_unit isst_checker u_isst_checker (.*);
